/* rtl/dpc_pkg.sv */
`default_nettype none

package dpc_pkg;

    typedef enum logic [3:0] {
        PH_IDLE   = 4'd0,
        PH_SEND_S = 4'd1,
        PH_WAIT_S = 4'd2,
        PH_SEND_L = 4'd3,
        PH_WAIT_L = 4'd4,
        PH_SEND_R = 4'd5,
        PH_WAIT_R = 4'd6,
        PH_SEND_T = 4'd7,
        PH_WAIT_T = 4'd8,
        PH_SEND_N = 4'd9,
        PH_WAIT_N = 4'd10,
        PH_ERROR  = 4'd11
    } phase_t;

    typedef enum logic [2:0] {
        ST_IDLE     = 3'd0,
        ST_CALLING  = 3'd1,
        ST_AUTH     = 3'd2,
        ST_STARTED  = 3'd3,
        ST_FUELLING = 3'd4,
        ST_STOP     = 3'd5,
        ST_END      = 3'd6
    } status_t;

    // item kinds
    localparam logic [1:0] KIND_TICK  = 2'd0;
    localparam logic [1:0] KIND_FRAME = 2'd1;
    localparam logic [1:0] KIND_HOST  = 2'd2;

    // host operations
    localparam logic [2:0] OP_START_VOL = 3'd0;
    localparam logic [2:0] OP_START_AMT = 3'd1;
    localparam logic [2:0] OP_TOTAL     = 3'd2;
    localparam logic [2:0] OP_STOP      = 3'd3;
    localparam logic [2:0] OP_RESUME    = 3'd4;
    localparam logic [2:0] OP_CLOSE     = 3'd5;

    // configuration register indexes
    localparam logic [2:0] CFG_IDLE_POLL   = 3'd0;
    localparam logic [2:0] CFG_ACTIVE_POLL = 3'd1;
    localparam logic [2:0] CFG_REPLY_TMO   = 3'd2;
    localparam logic [2:0] CFG_RETRY_LIMIT = 3'd3;
    localparam logic [2:0] CFG_ERROR_HOLD  = 3'd4;
    localparam logic [2:0] CFG_CLOSE_WAIT  = 3'd5;
    localparam logic [2:0] CFG_LINK_TMO    = 3'd6;

    // command letters
    localparam logic [7:0] CMD_S = 8'h53;
    localparam logic [7:0] CMD_L = 8'h4C;
    localparam logic [7:0] CMD_R = 8'h52;
    localparam logic [7:0] CMD_T = 8'h54;
    localparam logic [7:0] CMD_N = 8'h4E;
    localparam logic [7:0] CMD_C = 8'h43;
    localparam logic [7:0] CMD_V = 8'h56;
    localparam logic [7:0] CMD_M = 8'h4D;
    localparam logic [7:0] CMD_B = 8'h42;
    localparam logic [7:0] CMD_G = 8'h47;

    // digit characters
    localparam logic [7:0] CH_0 = 8'h30;
    localparam logic [7:0] CH_1 = 8'h31;
    localparam logic [7:0] CH_2 = 8'h32;
    localparam logic [7:0] CH_3 = 8'h33;
    localparam logic [7:0] CH_4 = 8'h34;
    localparam logic [7:0] CH_6 = 8'h36;
    localparam logic [7:0] CH_8 = 8'h38;
    localparam logic [7:0] CH_9 = 8'h39;

    // minimum data lengths
    localparam logic [5:0] LEN_STATUS = 6'd2;
    localparam logic [5:0] LEN_LR     = 6'd10;
    localparam logic [5:0] LEN_TOTAL  = 6'd11;
    localparam logic [5:0] LEN_T      = 6'd22;

    localparam logic [19:0] MAX6      = 20'd999999;
    localparam logic [29:0] MAX9      = 30'd999999999;
    localparam logic [3:0]  MAX_NOZ   = 4'd9;
    localparam logic [13:0] MAX_PRICE = 14'd9999;
    localparam logic [15:0] TMAX      = 16'hFFFF;

    localparam logic [15:0] RST_IDLE_POLL   = 16'd500;
    localparam logic [15:0] RST_ACTIVE_POLL = 16'd200;
    localparam logic [15:0] RST_REPLY_TMO   = 16'd100;
    localparam logic [1:0]  RST_RETRY_LIMIT = 2'd3;
    localparam logic [15:0] RST_ERROR_HOLD  = 16'd500;
    localparam logic [15:0] RST_CLOSE_WAIT  = 16'd200;
    localparam logic [15:0] RST_LINK_TMO    = 16'd2000;

    typedef struct packed {
        logic [1:0]  kind;
        logic        rx_ok;
        logic [7:0]  rx_cmd;
        logic [7:0]  rx_first_char;
        logic [7:0]  rx_second_char;
        logic [5:0]  rx_data_len;
        logic [29:0] rx_value_a;
        logic [19:0] rx_value_b;
        logic [2:0]  host_op;
        logic [3:0]  host_nozzle;
        logic [19:0] host_quantity;
        logic [13:0] host_price;
    } item_t;

    typedef struct packed {
        logic        tx_valid;
        logic [7:0]  tx_cmd;
        logic [3:0]  tx_nozzle;
        logic [19:0] tx_quantity;
        logic [13:0] tx_price;
        logic [2:0]  pump_status;
        logic [7:0]  nozzle_out;
        logic [7:0]  sale_id;
        logic [19:0] sale_volume;
        logic [19:0] money_amount;
        logic [29:0] totalizer;
        logic        link_up;
    } result_t;

    function automatic logic [19:0] sat6_30(input logic [29:0] v);
        return (v > 30'(MAX6)) ? MAX6 : v[19:0];
    endfunction

    function automatic logic [19:0] sat6_20(input logic [19:0] v);
        return (v > MAX6) ? MAX6 : v;
    endfunction

endpackage

`default_nettype wire

/* rtl/dispenser_poll_controller.sv */
`default_nettype none

// Channel   Signals                              Direction
// item      item_valid, item_stall, item        tick, reply frame or host command in
// result    result_valid, result_stall, result  frame to send and tracked state out
// cfg       cfg_write, cfg_index, cfg_data      register writes
//
// One item per clock: the whole state update is done in the cycle the beat is
// taken, and its result lands in the output register on the same edge.
// The result register frees the input side: a new beat is taken unless a held
// result is stalled. Reset loads register defaults, phase idle, timers zero.

module dispenser_poll_controller (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            item_valid,
    output logic                 item_stall,
    input  wire dpc_pkg::item_t  item,
    output logic                 result_valid,
    input  wire logic            result_stall,
    output dpc_pkg::result_t     result,
    input  wire logic            cfg_write,
    input  wire logic [2:0]      cfg_index,
    input  wire logic [15:0]     cfg_data
);
    import dpc_pkg::*;

    logic [15:0] idle_poll_reg, active_poll_reg, reply_tmo_reg;
    logic [15:0] error_hold_reg, close_wait_reg, link_tmo_reg;
    logic [1:0]  retry_limit_reg;

    phase_t      phase_reg, phase_next;
    logic [15:0] phase_timer_reg, phase_timer_next;
    logic [1:0]  retry_reg, retry_next;
    logic        close_sent_reg, close_sent_next;
    status_t     status_reg, status_next;
    logic [7:0]  nozzle_reg, nozzle_next;
    logic [7:0]  tid_reg, tid_next;
    logic [19:0] volume_reg, volume_next;
    logic [19:0] amount_reg, amount_next;
    logic [29:0] total_reg, total_next;
    logic        connected_reg, connected_next;
    logic [15:0] silence_reg, silence_next;

    logic        result_valid_reg;
    result_t     result_reg, result_next;

    logic        accept;

    phase_t      go_phase;
    logic        go_en, go_keep, act;
    logic [15:0] lim;

    assign item_stall   = result_valid_reg && result_stall;
    assign accept       = item_valid && !item_stall;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idle_poll_reg   <= RST_IDLE_POLL;
            active_poll_reg <= RST_ACTIVE_POLL;
            reply_tmo_reg   <= RST_REPLY_TMO;
            retry_limit_reg <= RST_RETRY_LIMIT;
            error_hold_reg  <= RST_ERROR_HOLD;
            close_wait_reg  <= RST_CLOSE_WAIT;
            link_tmo_reg    <= RST_LINK_TMO;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_IDLE_POLL:   idle_poll_reg   <= cfg_data;
                CFG_ACTIVE_POLL: active_poll_reg <= cfg_data;
                CFG_REPLY_TMO:   reply_tmo_reg   <= cfg_data;
                CFG_RETRY_LIMIT: retry_limit_reg <= cfg_data[1:0];
                CFG_ERROR_HOLD:  error_hold_reg  <= cfg_data;
                CFG_CLOSE_WAIT:  close_wait_reg  <= cfg_data;
                CFG_LINK_TMO:    link_tmo_reg    <= cfg_data;
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        phase_next       = phase_reg;
        phase_timer_next = phase_timer_reg;
        retry_next       = retry_reg;
        close_sent_next  = close_sent_reg;
        status_next      = status_reg;
        nozzle_next      = nozzle_reg;
        tid_next         = tid_reg;
        volume_next      = volume_reg;
        amount_next      = amount_reg;
        total_next       = total_reg;
        connected_next   = connected_reg;
        silence_next     = silence_reg;
        go_en            = 1'b0;
        go_keep          = 1'b0;
        go_phase         = PH_IDLE;
        act              = 1'b0;
        lim              = idle_poll_reg;
        result_next      = '0;

        case (item.kind)
            KIND_TICK:
            begin
                if (phase_timer_reg != TMAX)
                    phase_timer_next = phase_timer_reg + 16'd1;
                if (silence_reg != TMAX)
                    silence_next = silence_reg + 16'd1;
                case (phase_reg)
                    PH_IDLE:
                    begin
                        if (status_reg inside {ST_FUELLING, ST_STARTED, ST_STOP})
                            lim = active_poll_reg;
                        if (phase_timer_next > lim)
                        begin
                            go_en = 1'b1; go_phase = PH_SEND_S;
                        end
                    end
                    PH_SEND_S:
                    begin
                        result_next.tx_valid = 1'b1; result_next.tx_cmd = CMD_S;
                        go_en = 1'b1; go_phase = PH_WAIT_S; go_keep = 1'b1;
                    end
                    PH_SEND_L:
                    begin
                        result_next.tx_valid = 1'b1; result_next.tx_cmd = CMD_L;
                        go_en = 1'b1; go_phase = PH_WAIT_L; go_keep = 1'b1;
                    end
                    PH_SEND_R:
                    begin
                        result_next.tx_valid = 1'b1; result_next.tx_cmd = CMD_R;
                        go_en = 1'b1; go_phase = PH_WAIT_R; go_keep = 1'b1;
                    end
                    PH_SEND_T:
                    begin
                        result_next.tx_valid = 1'b1; result_next.tx_cmd = CMD_T;
                        go_en = 1'b1; go_phase = PH_WAIT_T; go_keep = 1'b1;
                    end
                    PH_SEND_N:
                    begin
                        result_next.tx_valid = 1'b1; result_next.tx_cmd = CMD_N;
                        go_en = 1'b1; go_phase = PH_WAIT_N;
                    end
                    PH_WAIT_S, PH_WAIT_L, PH_WAIT_R:
                    begin
                        if (phase_timer_next > reply_tmo_reg)
                        begin
                            go_en = 1'b1;
                            if (retry_reg < retry_limit_reg)
                            begin
                                // retry: keep the count and resend
                                retry_next = retry_reg + 2'd1;
                                go_keep    = 1'b1;
                                case (phase_reg)
                                    PH_WAIT_S: go_phase = PH_SEND_S;
                                    PH_WAIT_L: go_phase = PH_SEND_L;
                                    default:   go_phase = PH_SEND_R;
                                endcase
                            end
                            else if (phase_reg == PH_WAIT_S)
                                go_phase = PH_ERROR;
                            else
                                go_phase = PH_IDLE;
                        end
                    end
                    PH_WAIT_T:
                    begin
                        if (phase_timer_next > reply_tmo_reg)
                            go_en = 1'b1;
                    end
                    PH_WAIT_N:
                    begin
                        if (phase_timer_next > close_wait_reg)
                        begin
                            go_en = 1'b1; go_phase = PH_SEND_S;
                        end
                    end
                    PH_ERROR:
                    begin
                        connected_next  = 1'b0;
                        close_sent_next = 1'b0;
                        if (phase_timer_next > error_hold_reg)
                            go_en = 1'b1;
                    end
                    default:
                        go_en = 1'b1;
                endcase
            end
            KIND_FRAME:
            begin
                if (item.rx_ok)
                begin
                    case (phase_reg)
                        PH_WAIT_S:
                        begin
                            if (item.rx_cmd == CMD_S)
                            begin
                                go_en = 1'b1;
                                if (item.rx_data_len >= LEN_STATUS)
                                begin
                                    nozzle_next    = item.rx_first_char - CH_0;
                                    connected_next = 1'b1;
                                    silence_next   = '0;
                                    if (item.rx_first_char == CH_9 && item.rx_second_char == CH_0)
                                    begin
                                        status_next = ST_END; act = 1'b1;
                                    end
                                    else if (item.rx_first_char == CH_1
                                             && item.rx_second_char == CH_0)
                                        status_next = ST_IDLE;
                                    else if (item.rx_first_char == CH_2
                                             && item.rx_second_char == CH_1)
                                        status_next = ST_CALLING;
                                    else if (item.rx_first_char == CH_3
                                             && item.rx_second_char == CH_1)
                                    begin
                                        status_next = ST_AUTH;
                                        // drop the previous sale on a fresh authorize
                                        if (volume_reg != '0 || amount_reg != '0)
                                        begin
                                            volume_next = '0;
                                            amount_next = '0;
                                            tid_next    = '0;
                                        end
                                    end
                                    else if (item.rx_first_char == CH_4
                                             && item.rx_second_char == CH_1)
                                        status_next = ST_STARTED;
                                    else if (item.rx_first_char == CH_6
                                             && item.rx_second_char == CH_1)
                                    begin
                                        status_next = ST_FUELLING; act = 1'b1;
                                    end
                                    else if (item.rx_first_char == CH_8
                                             && item.rx_second_char == CH_1)
                                    begin
                                        status_next = ST_STOP; act = 1'b1;
                                    end
                                    else
                                        status_next = ST_IDLE;

                                    if (act && status_next == ST_FUELLING)
                                        go_phase = PH_SEND_L;
                                    else if (act && status_next == ST_STOP)
                                    begin
                                        if (!close_sent_reg)
                                        begin
                                            close_sent_next = 1'b1;
                                            go_phase        = PH_SEND_T;
                                        end
                                    end
                                    else if (act && status_next == ST_END)
                                    begin
                                        close_sent_next = 1'b0;
                                        go_phase        = PH_SEND_N;
                                    end
                                end
                            end
                        end
                        PH_WAIT_L:
                        begin
                            if (item.rx_cmd == CMD_L)
                            begin
                                if (item.rx_data_len >= LEN_LR)
                                begin
                                    nozzle_next = item.rx_first_char - CH_0;
                                    tid_next    = item.rx_second_char;
                                    volume_next = sat6_30(item.rx_value_a);
                                end
                                go_en = 1'b1; go_phase = PH_SEND_R;
                            end
                        end
                        PH_WAIT_R:
                        begin
                            if (item.rx_cmd == CMD_R)
                            begin
                                if (item.rx_data_len >= LEN_LR)
                                    amount_next = sat6_30(item.rx_value_a);
                                go_en = 1'b1;
                            end
                        end
                        PH_WAIT_T:
                        begin
                            if (item.rx_cmd == CMD_T)
                            begin
                                if (item.rx_data_len >= LEN_T)
                                begin
                                    nozzle_next = item.rx_first_char - CH_0;
                                    tid_next    = item.rx_second_char;
                                    amount_next = sat6_30(item.rx_value_a);
                                    volume_next = sat6_20(item.rx_value_b);
                                end
                                go_en = 1'b1;
                            end
                        end
                        default:
                        begin
                            if (item.rx_cmd == CMD_C && item.rx_data_len >= LEN_TOTAL)
                                total_next = (item.rx_value_a > MAX9) ? MAX9 : item.rx_value_a;
                        end
                    endcase
                end
            end
            KIND_HOST:
            begin
                case (item.host_op)
                    OP_START_VOL, OP_START_AMT:
                    begin
                        volume_next     = '0;
                        amount_next     = '0;
                        tid_next        = '0;
                        close_sent_next = 1'b0;
                        result_next.tx_valid = 1'b1;
                        result_next.tx_cmd   = (item.host_op == OP_START_VOL) ? CMD_V : CMD_M;
                        result_next.tx_nozzle = (item.host_nozzle > MAX_NOZ) ?
                                                MAX_NOZ : item.host_nozzle;
                        result_next.tx_quantity = sat6_20(item.host_quantity);
                        result_next.tx_price = (item.host_price > MAX_PRICE) ?
                                               MAX_PRICE : item.host_price;
                    end
                    OP_TOTAL:
                    begin
                        result_next.tx_valid = 1'b1; result_next.tx_cmd = CMD_C;
                    end
                    OP_STOP:
                    begin
                        result_next.tx_valid = 1'b1; result_next.tx_cmd = CMD_B;
                    end
                    OP_RESUME:
                    begin
                        result_next.tx_valid = 1'b1; result_next.tx_cmd = CMD_G;
                    end
                    OP_CLOSE:
                    begin
                        result_next.tx_valid = 1'b1; result_next.tx_cmd = CMD_N;
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase

        // phase change restarts the timer; a retry and the S, L, R and T send steps keep the retry count
        if (go_en && phase_reg != go_phase)
        begin
            phase_next       = go_phase;
            phase_timer_next = '0;
            if (!go_keep)
                retry_next = '0;
        end

        // drop the link after too long without a status reply
        if (item.kind == KIND_TICK && silence_next > link_tmo_reg && connected_next)
        begin
            connected_next = 1'b0;
            if (phase_next != PH_ERROR)
            begin
                phase_next       = PH_ERROR;
                phase_timer_next = '0;
                retry_next       = '0;
            end
        end

        result_next.pump_status    = status_next;
        result_next.nozzle_out     = nozzle_next;
        result_next.sale_id        = tid_next;
        result_next.sale_volume    = volume_next;
        result_next.money_amount   = amount_next;
        result_next.totalizer      = total_next;
        result_next.link_up        = connected_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_IDLE;
            phase_timer_reg  <= '0;
            retry_reg        <= '0;
            close_sent_reg   <= 1'b0;
            status_reg       <= ST_IDLE;
            nozzle_reg       <= '0;
            tid_reg          <= '0;
            volume_reg       <= '0;
            amount_reg       <= '0;
            total_reg        <= '0;
            connected_reg    <= 1'b0;
            silence_reg      <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg       <= phase_next;
                phase_timer_reg <= phase_timer_next;
                retry_reg       <= retry_next;
                close_sent_reg  <= close_sent_next;
                status_reg      <= status_next;
                nozzle_reg      <= nozzle_next;
                tid_reg         <= tid_next;
                volume_reg      <= volume_next;
                amount_reg      <= amount_next;
                total_reg       <= total_next;
                connected_reg   <= connected_next;
                silence_reg     <= silence_next;
            end
            if (accept)
                result_valid_reg <= 1'b1;
            else if (!result_stall)
                result_valid_reg <= 1'b0;
        end
    end

    // hold the result beat while stalled
    always_ff @(posedge clk)
    begin
        if (accept)
            result_reg <= result_next;
    end

endmodule

`default_nettype wire
